// ===== design/vcls_pkg.sv =====
package vcls_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_COEFF_X = 2'd2;
    localparam logic [1:0] CFG_COEFF_Y = 2'd3;

    localparam int SIZE_W   = 11;
    localparam int U_W      = 32;
    localparam int C_W      = 16;
    localparam int K_W      = 32;
    localparam int OUT_W    = 48;
    localparam int IDX_W    = 10;
    localparam int SQ_W     = 32;
    localparam int WT_W     = 33;
    localparam int DIF_W    = 33;
    localparam int ACC_W    = 68;
    localparam int D_W      = 44;
    localparam int TERM_W   = 78;

    // One grid sample as it travels through the window
    typedef struct packed {
        logic signed [U_W-1:0] u;
        logic        [C_W-1:0] c;
    } t_sample;

    // Three samples along one axis, minus / center / plus
    typedef struct packed {
        t_sample m;
        t_sample z;
        t_sample p;
    } t_axis;

    // Side information that rides along with a result through the pipe
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_tag;

endpackage

// ===== design/vcls_if.sv =====
interface vcls_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   solution_sample;
    logic        [15:0]   speed_sample;
    modport source (output valid, solution_sample, speed_sample, input ready);
    modport sink   (input valid, solution_sample, speed_sample, output ready);
endinterface

interface vcls_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [47:0]   laplacian_value;
    logic        [9:0]    row_index;
    logic        [9:0]    column_index;
    logic                 last_of_frame;
    modport source (output valid, laplacian_value, row_index, column_index, last_of_frame,
                    input ready);
    modport sink   (input valid, laplacian_value, row_index, column_index, last_of_frame,
                     output ready);
endinterface

interface vcls_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/vcls_axis_cell.sv =====
// One axis of the stencil as a short chain of pipeline cells. Each stage
// hands its partial result to the next one every enabled cycle.
//   s1: squares of c, differences of u
//   s2: weights A, B
//   s3: A*dp, B*dm (two 33x33 products)
//   s4: sum and floor shift -> D
//   s5: D*coeff split into high and low partial products
//   s6: recombine -> scaled term
module vcls_axis_cell (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  vcls_pkg::t_axis                    i_axis,
    input  logic [vcls_pkg::K_W-1:0]           i_coeff,
    output logic signed [vcls_pkg::TERM_W-1:0] o_term
);
    localparam int SQ = vcls_pkg::SQ_W;
    localparam int DW = vcls_pkg::DIF_W;
    localparam int AW = vcls_pkg::ACC_W;
    localparam int DD = vcls_pkg::D_W;
    localparam int TW = vcls_pkg::TERM_W;

    logic [SQ-1:0]        r_sqm, r_sqz, r_sqp;
    logic signed [DW-1:0] r_dp1, r_dm1, r_dp2, r_dm2;
    logic [SQ:0]          r_wa, r_wb;
    logic signed [AW-1:0] r_pa, r_pb;
    logic signed [DD-1:0] r_d;
    logic [15:0]          r_khi, r_klo, r_khi4, r_klo4;
    logic [15:0]          r_khi2, r_klo2, r_khi3, r_klo3;
    logic signed [TW-1:0] r_ph, r_pl, r_term;
    logic signed [AW-1:0] w_sum;

    assign w_sum = r_pa + r_pb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_sqm <= i_axis.m.c * i_axis.m.c;
            r_sqz <= i_axis.z.c * i_axis.z.c;
            r_sqp <= i_axis.p.c * i_axis.p.c;
            r_dp1 <= DW'(i_axis.p.u) - DW'(i_axis.z.u);
            r_dm1 <= DW'(i_axis.m.u) - DW'(i_axis.z.u);
            r_khi <= i_coeff[31:16];
            r_klo <= i_coeff[15:0];
            // stage 2
            r_wa  <= (SQ+1)'(r_sqp) + (SQ+1)'(r_sqz);
            r_wb  <= (SQ+1)'(r_sqz) + (SQ+1)'(r_sqm);
            r_dp2 <= r_dp1;
            r_dm2 <= r_dm1;
            r_khi2 <= r_khi;
            r_klo2 <= r_klo;
            // stage 3
            r_pa  <= AW'($signed({1'b0, r_wa})) * AW'(r_dp2);
            r_pb  <= AW'($signed({1'b0, r_wb})) * AW'(r_dm2);
            r_khi3 <= r_khi2;
            r_klo3 <= r_klo2;
            // stage 4: floor divide by 2^24 (arithmetic shift floors)
            r_d    <= DD'(w_sum >>> 24);
            r_khi4 <= r_khi3;
            r_klo4 <= r_klo3;
            // stage 5
            r_ph <= TW'(r_d) * TW'($signed({1'b0, r_khi4}));
            r_pl <= TW'(r_d) * TW'($signed({1'b0, r_klo4}));
            // stage 6
            r_term <= r_ph + (r_pl >>> 16);
        end
    end

    assign o_term = r_term;
endmodule

// ===== design/vcls_window.sv =====
// Line stores plus the 3x3 window. Each column of the window is a cell that
// shifts left once per accepted sample, after the registered store read.
module vcls_window #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_acc,
    input  logic [$clog2(MAX_COLUMNS)-1:0]    i_addr,
    input  vcls_pkg::t_sample                 i_now,
    output vcls_pkg::t_axis                   o_xaxis,
    output vcls_pkg::t_axis                   o_yaxis
);
    vcls_pkg::t_sample mem_top [MAX_COLUMNS];
    vcls_pkg::t_sample mem_mid [MAX_COLUMNS];
    vcls_pkg::t_sample r_win [3][3];
    vcls_pkg::t_sample r_now;
    vcls_pkg::t_sample r_rtop, r_rmid;
    logic              r_vld;

    // Read the stores on acceptance, then shift the window on the next pipe step.
    // Stores write back the mid line into top and the new sample into mid.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rtop <= mem_top[i_addr];
            r_rmid <= mem_mid[i_addr];
            mem_top[i_addr] <= mem_mid[i_addr];
            mem_mid[i_addr] <= i_now;
            r_now  <= i_now;
        end
    end

    // Marks fresh read data waiting to enter the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_acc;
        end
    end

    // No bypass for the same column written back to back: successive samples use
    // different columns (width >= 3) unless a size write resets the raster position.
    always_ff @(posedge i_clk) begin
        if (i_en && r_vld) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_rtop;
            r_win[1][2] <= r_rmid;
            r_win[2][2] <= r_now;
        end
    end

    assign o_xaxis = '{m: r_win[1][0], z: r_win[1][1], p: r_win[1][2]};
    assign o_yaxis = '{m: r_win[0][1], z: r_win[1][1], p: r_win[2][1]};
endmodule

// ===== design/variable_coeff_laplacian_stencil.sv =====
// Channel  | Role   | Payload
// ---------+--------+-----------------------------------------------------------
// in       | sink   | solution_sample (s32 Q16.16), speed_sample (u16 Q4.12)
// out      | source | laplacian_value (s48), row_index, column_index, last_of_frame
// cfg      | sink   | index (2b), data (32b): columns, rows, coeff_x, coeff_y
//
// One sample is taken per clock when the pipe moves; a result is presented once its sample
// has passed the store read, window shift, six cell stages and output register. The whole
// pipe advances together on one enable, so a stalled output holds everything, and the last
// results drain on idle input cycles. Input is held off while a configuration write is
// offered. Reset (synchronous, active low) clears raster position and result valids, sets
// sizes to 1024 (clamped to the maximums) and sets both coefficients to 65536.
module variable_coeff_laplacian_stencil #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vcls_in_if.sink    in_ch,
    vcls_out_if.source out_ch,
    vcls_cfg_if.sink   cfg_ch
);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int SW    = vcls_pkg::SIZE_W + 3;
    localparam int LAT   = 8;
    localparam int TW    = vcls_pkg::TERM_W;

    logic [SW-1:0]  r_cols, r_rows, n_cols;
    logic [31:0]    r_kx, r_ky;
    logic [SW-1:0]  r_pr, r_pc;
    vcls_pkg::t_tag r_tag [LAT];
    logic           r_ovalid;
    logic signed [47:0] r_oval;
    logic [9:0]     r_orow, r_ocol;
    logic           r_olast;
    logic           w_en, w_acc;
    vcls_pkg::t_axis w_xa, w_ya;
    logic signed [TW-1:0] w_tx, w_ty, w_sum;
    logic [SW-1:0]  w_clamp;

    // Pipe moves when the output slot is free or being taken
    assign w_en    = !r_ovalid || out_ch.ready;
    assign in_ch.ready = w_en && !cfg_ch.valid;
    assign w_acc   = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    function automatic logic [SW-1:0] clamp(input logic [10:0] v, input int hi);
        if (v < 11'd3) return SW'(3);
        if (SW'(v) > SW'(hi)) return SW'(hi);
        return SW'(v);
    endfunction

    // Configuration registers and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= clamp(11'd1024, MAX_COLUMNS);
            r_rows <= clamp(11'd1024, MAX_ROWS);
            r_kx   <= 32'd65536;
            r_ky   <= 32'd65536;
            r_pr   <= '0;
            r_pc   <= '0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                vcls_pkg::CFG_COLUMNS: begin
                    r_cols <= clamp(cfg_ch.data[10:0], MAX_COLUMNS);
                    r_pr <= '0; r_pc <= '0;
                end
                vcls_pkg::CFG_ROWS: begin
                    r_rows <= clamp(cfg_ch.data[10:0], MAX_ROWS);
                    r_pr <= '0; r_pc <= '0;
                end
                vcls_pkg::CFG_COEFF_X: r_kx <= cfg_ch.data;
                vcls_pkg::CFG_COEFF_Y: r_ky <= cfg_ch.data;
                default: ;
            endcase
        end else if (w_acc) begin
            if (r_pc + 1'b1 >= r_cols) begin
                r_pc <= '0;
                r_pr <= (r_pr + 1'b1 >= r_rows) ? '0 : r_pr + 1'b1;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end
    assign n_cols = r_cols;
    assign w_clamp = n_cols;

    vcls_window #(.MAX_COLUMNS(MAX_COLUMNS)) u_win (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_acc  (w_acc),
        .i_addr (r_pc[CW-1:0]),
        .i_now  ('{u: in_ch.solution_sample, c: in_ch.speed_sample}),
        .o_xaxis(w_xa),
        .o_yaxis(w_ya)
    );

    vcls_axis_cell u_ax (
        .i_clk(i_clk), .i_en(w_en), .i_axis(w_xa), .i_coeff(r_kx), .o_term(w_tx));
    vcls_axis_cell u_ay (
        .i_clk(i_clk), .i_en(w_en), .i_axis(w_ya), .i_coeff(r_ky), .o_term(w_ty));

    // Tag chain: stage 0 is set at acceptance, stage 1 when the window shifts,
    // stages 2 to 7 follow the six cell stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_tag[k] <= '0;
        end else if (w_en) begin
            r_tag[0].valid <= w_acc && r_pr >= SW'(2) && r_pc >= SW'(2);
            r_tag[0].row   <= 10'(r_pr - SW'(2));
            r_tag[0].col   <= 10'(r_pc - SW'(2));
            r_tag[0].last  <= (r_pr + 1'b1 == r_rows) && (r_pc + 1'b1 == w_clamp);
            for (int k = 1; k < LAT; k++) r_tag[k] <= r_tag[k-1];
        end
    end

    assign w_sum = w_tx + w_ty;

    // Output register with saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= r_tag[LAT-1].valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sum > TW'(48'sh7FFF_FFFF_FFFF))       r_oval <= 48'sh7FFF_FFFF_FFFF;
            else if (w_sum < -(TW'(1) <<< 47))          r_oval <= 48'sh8000_0000_0000;
            else                                        r_oval <= w_sum[47:0];
            r_orow  <= r_tag[LAT-1].row;
            r_ocol  <= r_tag[LAT-1].col;
            r_olast <= r_tag[LAT-1].last;
        end
    end

    assign out_ch.valid           = r_ovalid;
    assign out_ch.laplacian_value = r_oval;
    assign out_ch.row_index       = r_orow;
    assign out_ch.column_index    = r_ocol;
    assign out_ch.last_of_frame   = r_olast;
endmodule

// ===== design/vcls_checker.sv =====
module vcls_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [9:0] out_row,
    input logic [9:0] out_col,
    input logic out_last,
    input logic cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
                                    && $stable(out_last))
        else $error("output changed while stalled");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n) cfg_ready)
        else $error("config port not ready");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid after reset");
endmodule

bind variable_coeff_laplacian_stencil vcls_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_row(out_ch.row_index), .out_col(out_ch.column_index),
    .out_last(out_ch.last_of_frame), .cfg_ready(cfg_ch.ready));
